### sv/sfpf_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helpers for the scrolled frame pixel fetch block.
// No dependencies; the files that use it refer to this package by scoped names.
package sfpf_pkg;

	localparam int SRC_ROWS_DEF   = 32;
	localparam int SRC_COLS_DEF   = 32;
	localparam int MAX_FRAMES_DEF = 8;
	localparam int TGT_ROWS_DEF   = 64;
	localparam int TGT_COLS_DEF   = 64;

	localparam int TI_W      = 12;   // target index width
	localparam int COLOR_W   = 24;
	localparam int GEO_W     = 12;   // signed geometry arithmetic width
	localparam int CNT_W     = 8;    // frame count width (holds MAX_FRAMES)
	localparam int CFG_W     = 8;    // widest register
	localparam int CFG_IDX_W = 3;
	localparam int NF_W      = 4;

	typedef enum logic [1:0] {
		OP_LOAD = 2'd0,
		OP_DRAW = 2'd1,
		OP_NEXT = 2'd2,
		OP_PREV = 2'd3
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SRC_ROWS   = 3'd0,
		REG_SRC_COLS   = 3'd1,
		REG_NUM_FRAMES = 3'd2,
		REG_ROW_SHIFT  = 3'd3,
		REG_COL_SHIFT  = 3'd4,
		REG_FILL       = 3'd5,
		REG_ORIGIN_ROW = 3'd6,
		REG_ORIGIN_COL = 3'd7
	} cfg_idx_t;

	typedef struct packed {
		logic [5:0]      src_rows;
		logic [5:0]      src_cols;
		logic [NF_W-1:0] num_frames;
		logic [6:0]      row_shift;
		logic [6:0]      col_shift;
		logic            fill_enable;
		logic [7:0]      origin_row;
		logic [7:0]      origin_col;
	} cfg_t;

	// decode of one input beat
	typedef struct packed {
		logic            hit;    // draw that yields a pixel
		logic            wr;     // load inside the store
		logic            step;   // next or previous frame
		logic [TI_W-1:0] target;
	} dec_t;

	// frame count in use: zero acts as one, clamp at the store size
	function automatic logic [CNT_W-1:0] eff_frames(input logic [NF_W-1:0] nf,
		input int max_frames);
		logic [CNT_W-1:0] n;
		n = CNT_W'(nf);
		if (n == '0) begin
			n = CNT_W'(1);
		end else if (int'(n) > max_frames) begin
			n = CNT_W'(max_frames);
		end
		return n;
	endfunction

endpackage

### sv/sfpf_store.sv
`timescale 1ns / 1ps
// Frame store: single-port synchronous RAM, one access per cycle,
// read data registered. Uses no package items.
module sfpf_store #(
	parameter int AW = 13,
	parameter int DW = 24
) (
	input  logic          clk,
	input  logic          we,
	input  logic          re,
	input  logic [AW-1:0] addr,
	input  logic [DW-1:0] wdata,
	output logic [DW-1:0] rdata_s1
);

	logic [DW-1:0] mem [2**AW];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
	end

	// hold read data unless a new read is issued
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_s1 <= mem[addr];
		end
	end

endmodule

### sv/sfpf_geom.sv
`timescale 1ns / 1ps
// Geometry decode: shift, fill frame choice, clipping, store address and
// panel index for one input beat. Depends on sfpf_pkg.
module sfpf_geom #(
	parameter int SRC_ROWS   = sfpf_pkg::SRC_ROWS_DEF,
	parameter int SRC_COLS   = sfpf_pkg::SRC_COLS_DEF,
	parameter int MAX_FRAMES = sfpf_pkg::MAX_FRAMES_DEF,
	parameter int TGT_ROWS   = sfpf_pkg::TGT_ROWS_DEF,
	parameter int TGT_COLS   = sfpf_pkg::TGT_COLS_DEF,
	parameter int FW         = 3,
	parameter int AW         = 13
) (
	input  logic [1:0]          opcode,
	input  logic [2:0]          frame_select,
	input  logic [4:0]          pixel_row,
	input  logic [4:0]          pixel_col,
	input  sfpf_pkg::cfg_t      cfg,
	input  logic [FW-1:0]       cur_frame,
	output sfpf_pkg::dec_t      dec,
	output logic [AW-1:0]       addr,
	output logic [FW-1:0]       frame_next
);

	localparam int GW = sfpf_pkg::GEO_W;
	localparam int CW = sfpf_pkg::CNT_W;
	localparam int TW = sfpf_pkg::TI_W;

	localparam logic signed [GW-1:0] TR_G  = GW'(TGT_ROWS);
	localparam logic signed [GW-1:0] TC_G  = GW'(TGT_COLS);
	localparam logic signed [GW-1:0] SR_G  = GW'(SRC_ROWS);
	localparam logic signed [GW-1:0] SC_G  = GW'(SRC_COLS);
	localparam logic [AW-1:0] FRAME_SZ = AW'(SRC_ROWS * SRC_COLS);
	localparam logic [AW-1:0] ROW_SZ   = AW'(SRC_COLS);
	localparam logic [TW-1:0] TC_MUL   = TW'(TGT_COLS);

	function automatic logic [FW-1:0] prev_f(input logic [FW-1:0] f,
		input logic [CW-1:0] n);
		return (f == '0) ? FW'(n - CW'(1)) : FW'(f - 1'b1);
	endfunction

	function automatic logic [FW-1:0] next_f(input logic [FW-1:0] f,
		input logic [CW-1:0] n);
		return ((CW'(f) + CW'(1)) >= n) ? '0 : FW'(f + 1'b1);
	endfunction

	sfpf_pkg::op_t          op;
	logic [CW-1:0]          n_eff;
	logic signed [GW-1:0]   rows_g, cols_g, rs, cs, r0, c0, rg, cg;
	logic signed [GW-1:0]   tr, tc, sr, sc;
	logic [FW-1:0]          fr, fsel;
	logic                   in_panel, in_src, ok, fill;
	logic [AW-1:0]          a_f, a_r, a_c;

	always_comb begin
		op     = sfpf_pkg::op_t'(opcode);
		n_eff  = sfpf_pkg::eff_frames(cfg.num_frames, MAX_FRAMES);
		fill   = cfg.fill_enable;
		rows_g = (GW'(cfg.src_rows) > SR_G) ? SR_G : GW'(cfg.src_rows);
		cols_g = (GW'(cfg.src_cols) > SC_G) ? SC_G : GW'(cfg.src_cols);
		rs     = GW'($signed(cfg.row_shift));
		cs     = GW'($signed(cfg.col_shift));
		r0     = GW'($signed(cfg.origin_row));
		c0     = GW'($signed(cfg.origin_col));
		rg     = GW'(pixel_row);
		cg     = GW'(pixel_col);
		tr     = r0 + rg;
		tc     = c0 + cg;
		sr     = rg - rs;
		sc     = cg - cs;
		fr     = cur_frame;
		fsel   = cur_frame;
		in_src = (rg < rows_g) && (cg < cols_g);
		in_panel = (r0 >= 0) && (c0 >= 0) && ((r0 + rows_g) <= TR_G)
			&& ((c0 + cols_g) <= TC_G);
		ok = 1'b1;

		if (in_panel) begin
			// rows first: wrap into the frame above or below
			if (sr < 0) begin
				if (!fill) ok = 1'b0;
				sr = sr + rows_g;
				if (sr < 0) ok = 1'b0;
				fr = prev_f(cur_frame, n_eff);
			end else if (sr >= rows_g) begin
				if (!fill) ok = 1'b0;
				sr = sr - rows_g;
				if (sr >= rows_g) ok = 1'b0;
				fr = next_f(cur_frame, n_eff);
			end
			fsel = fr;
			if (sc < 0) begin
				if (!fill) ok = 1'b0;
				sc = sc + cols_g;
				if (sc < 0) ok = 1'b0;
				fsel = prev_f(fr, n_eff);
			end else if (sc >= cols_g) begin
				if (!fill) ok = 1'b0;
				sc = sc - cols_g;
				if (sc >= cols_g) ok = 1'b0;
				fsel = next_f(fr, n_eff);
			end
		end else begin
			// partial placement: clip at the panel, no fill
			ok = (tr >= 0) && (tr < TR_G) && (tc >= 0) && (tc < TC_G)
				&& (sr >= 0) && (sr < rows_g) && (sc >= 0) && (sc < cols_g);
		end

		dec.hit    = (op == sfpf_pkg::OP_DRAW) && in_src && ok;
		dec.wr     = (op == sfpf_pkg::OP_LOAD) && (32'(frame_select) < MAX_FRAMES)
			&& (32'(pixel_row) < SRC_ROWS) && (32'(pixel_col) < SRC_COLS);
		dec.step   = (op == sfpf_pkg::OP_NEXT) || (op == sfpf_pkg::OP_PREV);
		dec.target = TW'($unsigned(tr)) * TC_MUL + TW'($unsigned(tc));

		frame_next = (op == sfpf_pkg::OP_NEXT) ? next_f(cur_frame, n_eff)
			: prev_f(cur_frame, n_eff);

		if (op == sfpf_pkg::OP_LOAD) begin
			a_f = AW'(frame_select);
			a_r = AW'(pixel_row);
			a_c = AW'(pixel_col);
		end else begin
			a_f = AW'(fsel);
			a_r = AW'($unsigned(sr));
			a_c = AW'($unsigned(sc));
		end
		addr = a_f * FRAME_SZ + a_r * ROW_SZ + a_c;
	end

endmodule

### sv/scrolled_frame_pixel_fetch.sv
`timescale 1ns / 1ps
// Top level of the scrolled frame pixel fetch: configuration registers,
// current frame, pipeline control. Uses sfpf_pkg, sfpf_geom, sfpf_store.
//
//  channel | handshake            | payload
//  --------+----------------------+---------------------------------------------
//  in      | in_valid / in_stall  | opcode frame_select pixel_row pixel_col load_color
//  out     | out_valid / out_stall| target_index pixel_color
//  cfg     | cfg_we               | cfg_index cfg_wdata
//
// One beat per cycle is accepted while in_stall is low; a draw result passes
// the synchronous frame store read and then the output register before it
// leaves. A stalled output holds one result and one more in flight.
// Reset clears control and configuration only; the frame store powers up
// undefined and is never cleared.
module scrolled_frame_pixel_fetch #(
	parameter int SRC_ROWS   = sfpf_pkg::SRC_ROWS_DEF,
	parameter int SRC_COLS   = sfpf_pkg::SRC_COLS_DEF,
	parameter int MAX_FRAMES = sfpf_pkg::MAX_FRAMES_DEF,
	parameter int TGT_ROWS   = sfpf_pkg::TGT_ROWS_DEF,
	parameter int TGT_COLS   = sfpf_pkg::TGT_COLS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [1:0]                        opcode,
	input  logic [2:0]                        frame_select,
	input  logic [4:0]                        pixel_row,
	input  logic [4:0]                        pixel_col,
	input  logic [sfpf_pkg::COLOR_W-1:0]      load_color,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [sfpf_pkg::TI_W-1:0]         target_index,
	output logic [sfpf_pkg::COLOR_W-1:0]      pixel_color,
	input  logic                              cfg_we,
	input  logic [sfpf_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [sfpf_pkg::CFG_W-1:0]        cfg_wdata
);

	localparam int FW    = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
	localparam int DEPTH = MAX_FRAMES * SRC_ROWS * SRC_COLS;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW    = sfpf_pkg::CNT_W;

	sfpf_pkg::cfg_t  cfg_q;
	logic [FW-1:0]   cur_q;
	sfpf_pkg::dec_t  dec;
	logic [AW-1:0]   addr;
	logic [FW-1:0]   frame_next;
	logic            in_accept, s1_go;
	logic            valid_s1;
	logic [sfpf_pkg::TI_W-1:0]    target_s1, target_q;
	logic [sfpf_pkg::COLOR_W-1:0] rdata_s1, color_q;
	logic            out_valid_q;
	logic [CW-1:0]   n_new;

	assign s1_go     = !out_valid_q || !out_stall;
	assign in_stall  = valid_s1 && !s1_go;
	assign in_accept = in_valid && !in_stall;
	assign n_new     = sfpf_pkg::eff_frames(cfg_wdata[sfpf_pkg::NF_W-1:0], MAX_FRAMES);

	sfpf_geom #(
		.SRC_ROWS   (SRC_ROWS),
		.SRC_COLS   (SRC_COLS),
		.MAX_FRAMES (MAX_FRAMES),
		.TGT_ROWS   (TGT_ROWS),
		.TGT_COLS   (TGT_COLS),
		.FW         (FW),
		.AW         (AW)
	) u_geom (
		.opcode       (opcode),
		.frame_select (frame_select),
		.pixel_row    (pixel_row),
		.pixel_col    (pixel_col),
		.cfg          (cfg_q),
		.cur_frame    (cur_q),
		.dec          (dec),
		.addr         (addr),
		.frame_next   (frame_next)
	);

	sfpf_store #(
		.AW (AW),
		.DW (sfpf_pkg::COLOR_W)
	) u_store (
		.clk      (clk),
		.we       (in_accept && dec.wr),
		.re       (in_accept && dec.hit),
		.addr     (addr),
		.wdata    (load_color),
		.rdata_s1 (rdata_s1)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.src_rows    <= 6'd32;
			cfg_q.src_cols    <= 6'd32;
			cfg_q.num_frames  <= sfpf_pkg::NF_W'(1);
			cfg_q.row_shift   <= '0;
			cfg_q.col_shift   <= '0;
			cfg_q.fill_enable <= 1'b0;
			cfg_q.origin_row  <= '0;
			cfg_q.origin_col  <= '0;
		end else if (cfg_we) begin
			case (sfpf_pkg::cfg_idx_t'(cfg_index))
				sfpf_pkg::REG_SRC_ROWS:   cfg_q.src_rows    <= cfg_wdata[5:0];
				sfpf_pkg::REG_SRC_COLS:   cfg_q.src_cols    <= cfg_wdata[5:0];
				sfpf_pkg::REG_NUM_FRAMES:
					cfg_q.num_frames <= cfg_wdata[sfpf_pkg::NF_W-1:0];
				sfpf_pkg::REG_ROW_SHIFT:  cfg_q.row_shift   <= cfg_wdata[6:0];
				sfpf_pkg::REG_COL_SHIFT:  cfg_q.col_shift   <= cfg_wdata[6:0];
				sfpf_pkg::REG_FILL:       cfg_q.fill_enable <= cfg_wdata[0];
				sfpf_pkg::REG_ORIGIN_ROW: cfg_q.origin_row  <= cfg_wdata;
				sfpf_pkg::REG_ORIGIN_COL: cfg_q.origin_col  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// current frame: rewind on a frame count that no longer covers it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q <= '0;
		end else if (cfg_we && (sfpf_pkg::cfg_idx_t'(cfg_index) == sfpf_pkg::REG_NUM_FRAMES)) begin
			if (CW'(cur_q) >= n_new) begin
				cur_q <= '0;
			end
		end else if (in_accept && dec.step) begin
			cur_q <= frame_next;
		end
	end

	// read stage and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_accept) begin
				valid_s1 <= dec.hit;
			end else if (s1_go) begin
				valid_s1 <= 1'b0;
			end
			if (s1_go) begin
				out_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept && dec.hit) begin
			target_s1 <= dec.target;
		end
		if (s1_go) begin
			target_q <= target_s1;
			color_q  <= rdata_s1;
		end
	end

	assign out_valid    = out_valid_q;
	assign target_index = target_q;
	assign pixel_color  = color_q;

`ifndef ASSERT_OFF
	a_stall_needs_s1: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1)
		else $error("input stalled with empty read stage");

	a_frame_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		CW'(cur_q) < sfpf_pkg::eff_frames(cfg_q.num_frames, MAX_FRAMES))
		else $error("current frame beyond frame count");

	a_s1_held: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && out_valid_q && out_stall |=> valid_s1 && $stable(target_s1))
		else $error("read stage lost a beat under stall");

	a_load_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept && (opcode == sfpf_pkg::OP_LOAD) |=> !valid_s1)
		else $error("load produced a result");
`endif

endmodule

### test/tb_scrolled_frame_pixel_fetch.sv
`timescale 1ns / 1ps
// Self-checking bench for scrolled_frame_pixel_fetch: a queue-fed driver, a result
// monitor and an in-order predictor of the frame store, frame stepping and placement.
// Depends on sfpf_pkg and the block's top level only.
module tb_scrolled_frame_pixel_fetch;

	localparam int SETTLE_CYCLES  = 6;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int HOLD_CYCLES    = 150;
	localparam int STORE_DEPTH    = sfpf_pkg::MAX_FRAMES_DEF * sfpf_pkg::SRC_ROWS_DEF
		* sfpf_pkg::SRC_COLS_DEF;

	typedef struct {
		sfpf_pkg::op_t opcode;
		logic [2:0]    frame_select;
		logic [4:0]    row;
		logic [4:0]    col;
		logic [23:0]   color;
	} fetch_req_t;

	typedef struct packed {
		logic [sfpf_pkg::TI_W-1:0]    target;
		logic [sfpf_pkg::COLOR_W-1:0] color;
	} pixel_out_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [1:0] opcode = 2'd0;
	logic [2:0] frame_select = 3'd0;
	logic [4:0] pixel_row = 5'd0;
	logic [4:0] pixel_col = 5'd0;
	logic [sfpf_pkg::COLOR_W-1:0] load_color = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [sfpf_pkg::TI_W-1:0] target_index;
	logic [sfpf_pkg::COLOR_W-1:0] pixel_color;
	logic cfg_we = 1'b0;
	logic [sfpf_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [sfpf_pkg::CFG_W-1:0] cfg_wdata = '0;

	// configuration copy, raw register contents
	logic [5:0]        cfg_rows = 6'd32;
	logic [5:0]        cfg_cols = 6'd32;
	logic [3:0]        cfg_frames = 4'd1;
	logic signed [6:0] cfg_rshift = '0;
	logic signed [7:0] cfg_orow = '0;
	logic signed [6:0] cfg_cshift = '0;
	logic signed [7:0] cfg_ocol = '0;
	logic              cfg_fill = 1'b0;

	// shown_frame/pixel_mem follow accepted beats, queued_frame/loaded follow the queue
	logic [sfpf_pkg::COLOR_W-1:0] pixel_mem [0:STORE_DEPTH-1];
	bit                 loaded [0:STORE_DEPTH-1];
	int                 shown_frame = 0;
	int                 queued_frame = 0;

	fetch_req_t pending_reqs[$];
	pixel_out_t expected_pixels[$];
	fetch_req_t cur_req;
	pixel_out_t want;
	bit         req_taken = 1'b0;
	int         beats_in = 0;
	int         mismatch_count = 0;
	int         idle_cycles = 0;
	int         hold_left = 0;
	bit         held_off = 1'b0;
	wire        steady_flow = (beats_in >= 900) && (beats_in < 1300);

	scrolled_frame_pixel_fetch u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.opcode(opcode), .frame_select(frame_select),
		.pixel_row(pixel_row), .pixel_col(pixel_col), .load_color(load_color),
		.out_valid(out_valid), .out_stall(out_stall),
		.target_index(target_index), .pixel_color(pixel_color),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic int frames_in_use();
		int n;
		n = cfg_frames;
		if (n < 1) begin
			n = 1;
		end else if (n > sfpf_pkg::MAX_FRAMES_DEF) begin
			n = sfpf_pkg::MAX_FRAMES_DEF;
		end
		return n;
	endfunction

	function automatic int frame_before(input int f, input int n);
		return (f <= 0) ? n - 1 : f - 1;
	endfunction

	function automatic int frame_after(input int f, input int n);
		return (f + 1 >= n) ? 0 : f + 1;
	endfunction

	function automatic int rows_in_use();
		return (cfg_rows > sfpf_pkg::SRC_ROWS_DEF) ? sfpf_pkg::SRC_ROWS_DEF : int'(cfg_rows);
	endfunction

	function automatic int cols_in_use();
		return (cfg_cols > sfpf_pkg::SRC_COLS_DEF) ? sfpf_pkg::SRC_COLS_DEF : int'(cfg_cols);
	endfunction

	// Find the store entry and panel index of a draw; 0 when the draw yields no pixel.
	function automatic bit locate_draw(input int r, input int c, input int cur,
		output int addr, output int tgt);
		int rows, cols, rs, cs, r0, c0, n, fr, f, sr, sc, tr, tc;
		rows = rows_in_use();
		cols = cols_in_use();
		rs = cfg_rshift;
		cs = cfg_cshift;
		r0 = cfg_orow;
		c0 = cfg_ocol;
		n = frames_in_use();
		addr = 0;
		tgt = 0;
		if (r >= rows || c >= cols) return 1'b0;
		tr = r0 + r;
		tc = c0 + c;
		if (r0 >= 0 && c0 >= 0 && r0 + rows <= sfpf_pkg::TGT_ROWS_DEF
			&& c0 + cols <= sfpf_pkg::TGT_COLS_DEF) begin
			// placement inside the panel: with fill on, uncovered area comes from the neighbor frames
			fr = cur;
			sr = r - rs;
			if (sr < 0) begin
				if (!cfg_fill) return 1'b0;
				sr += rows;
				if (sr < 0) return 1'b0;
				fr = frame_before(cur, n);
			end else if (sr >= rows) begin
				if (!cfg_fill) return 1'b0;
				sr -= rows;
				if (sr >= rows) return 1'b0;
				fr = frame_after(cur, n);
			end
			f = fr;
			sc = c - cs;
			if (sc < 0) begin
				if (!cfg_fill) return 1'b0;
				sc += cols;
				if (sc < 0) return 1'b0;
				f = frame_before(fr, n);
			end else if (sc >= cols) begin
				if (!cfg_fill) return 1'b0;
				sc -= cols;
				if (sc >= cols) return 1'b0;
				f = frame_after(fr, n);
			end
		end else begin
			// clip at the panel edge, no fill
			if (tr < 0 || tr >= sfpf_pkg::TGT_ROWS_DEF || tc < 0
				|| tc >= sfpf_pkg::TGT_COLS_DEF) return 1'b0;
			sr = r - rs;
			sc = c - cs;
			if (sr < 0 || sr >= rows || sc < 0 || sc >= cols) return 1'b0;
			f = cur;
		end
		addr = (f * sfpf_pkg::SRC_ROWS_DEF + sr) * sfpf_pkg::SRC_COLS_DEF + sc;
		tgt = (tr * sfpf_pkg::TGT_COLS_DEF + tc) & ((1 << sfpf_pkg::TI_W) - 1);
		return 1'b1;
	endfunction

	function automatic int store_addr(input logic [2:0] f, input logic [4:0] r,
		input logic [4:0] c);
		return (int'(f) * sfpf_pkg::SRC_ROWS_DEF + int'(r)) * sfpf_pkg::SRC_COLS_DEF
			+ int'(c);
	endfunction

	// Queue one beat; a draw that would read an entry never loaded gets a load first.
	task automatic queue_req(input sfpf_pkg::op_t op, input logic [2:0] fsel,
		input logic [4:0] r, input logic [4:0] c, input logic [23:0] color);
		fetch_req_t req;
		fetch_req_t fill_req;
		int addr, tgt;
		logic [12:0] a;
		req = '{op, fsel, r, c, color};
		case (op)
			sfpf_pkg::OP_LOAD: loaded[store_addr(fsel, r, c)] = 1'b1;
			sfpf_pkg::OP_NEXT: queued_frame = frame_after(queued_frame, frames_in_use());
			sfpf_pkg::OP_PREV: queued_frame = frame_before(queued_frame, frames_in_use());
			default: begin
				if (locate_draw(r, c, queued_frame, addr, tgt) && !loaded[addr]) begin
					a = 13'(addr);
					fill_req = '{sfpf_pkg::OP_LOAD, a[12:10], a[9:5], a[4:0],
						24'($urandom)};
					loaded[addr] = 1'b1;
					pending_reqs.push_back(fill_req);
				end
			end
		endcase
		pending_reqs.push_back(req);
	endtask

	// count covers the loads queued ahead of draws as well
	task automatic add_random_reqs(input int count);
		int pick, rows, cols, stop;
		logic [4:0] r, c;
		sfpf_pkg::op_t op;
		stop = pending_reqs.size() + count;
		while (pending_reqs.size() < stop) begin
			pick = $urandom_range(99);
			rows = rows_in_use();
			cols = cols_in_use();
			r = 5'($urandom);
			c = 5'($urandom);
			if (pick < 22) begin
				op = sfpf_pkg::OP_LOAD;
			end else if (pick < 26) begin
				op = sfpf_pkg::OP_NEXT;
			end else if (pick < 30) begin
				op = sfpf_pkg::OP_PREV;
			end else begin
				op = sfpf_pkg::OP_DRAW;
				// keep most draws inside the source rectangle
				if (rows > 0 && $urandom_range(9) < 8) r = 5'($urandom_range(rows - 1));
				if (cols > 0 && $urandom_range(9) < 8) c = 5'($urandom_range(cols - 1));
			end
			queue_req(op, 3'($urandom), r, c, 24'($urandom));
		end
	endtask

	task automatic wait_idle();
		while (pending_reqs.size() != 0 || in_valid || expected_pixels.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input sfpf_pkg::cfg_idx_t idx, input logic [7:0] val);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_wdata = val;
		case (idx)
			sfpf_pkg::REG_SRC_ROWS:   cfg_rows = val[5:0];
			sfpf_pkg::REG_SRC_COLS:   cfg_cols = val[5:0];
			sfpf_pkg::REG_ROW_SHIFT:  cfg_rshift = val[6:0];
			sfpf_pkg::REG_COL_SHIFT:  cfg_cshift = val[6:0];
			sfpf_pkg::REG_FILL:       cfg_fill = val[0];
			sfpf_pkg::REG_ORIGIN_ROW: cfg_orow = val;
			sfpf_pkg::REG_ORIGIN_COL: cfg_ocol = val;
			sfpf_pkg::REG_NUM_FRAMES: begin
				cfg_frames = val[3:0];
				if (shown_frame >= frames_in_use()) begin
					shown_frame = 0;
					queued_frame = 0;
				end
			end
			default: ;
		endcase
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic run_phase(input int rows, input int cols, input int frames,
		input int rshift, input int cshift, input int fill, input int orow, input int ocol,
		input int count);
		wait_idle();
		write_reg(sfpf_pkg::REG_SRC_ROWS, 8'(rows));
		write_reg(sfpf_pkg::REG_SRC_COLS, 8'(cols));
		write_reg(sfpf_pkg::REG_NUM_FRAMES, 8'(frames));
		write_reg(sfpf_pkg::REG_ROW_SHIFT, 8'(rshift));
		write_reg(sfpf_pkg::REG_COL_SHIFT, 8'(cshift));
		write_reg(sfpf_pkg::REG_FILL, 8'(fill));
		write_reg(sfpf_pkg::REG_ORIGIN_ROW, 8'(orow));
		write_reg(sfpf_pkg::REG_ORIGIN_COL, 8'(ocol));
		add_random_reqs(count);
	endtask

	// input side: track accepted beats and predict their results
	always @(posedge clk) begin
		int addr, tgt;
		req_taken = arst_n && in_valid && !in_stall;
		if (req_taken) begin
			beats_in++;
			case (cur_req.opcode)
				sfpf_pkg::OP_LOAD:
					pixel_mem[store_addr(cur_req.frame_select, cur_req.row, cur_req.col)]
						= cur_req.color;
				sfpf_pkg::OP_NEXT: shown_frame = frame_after(shown_frame, frames_in_use());
				sfpf_pkg::OP_PREV: shown_frame = frame_before(shown_frame, frames_in_use());
				default: begin
					if (locate_draw(cur_req.row, cur_req.col, shown_frame, addr, tgt))
						expected_pixels.push_back('{sfpf_pkg::TI_W'(tgt), pixel_mem[addr]});
				end
			endcase
		end
	end

	always @(negedge clk) begin
		// hold a stalled beat, otherwise offer the next one or idle
		if (!in_valid || req_taken) begin
			if (pending_reqs.size() != 0 && (steady_flow || $urandom_range(99) >= 29)) begin
				cur_req = pending_reqs.pop_front();
				in_valid <= 1'b1;
				opcode <= cur_req.opcode;
				frame_select <= cur_req.frame_select;
				pixel_row <= cur_req.row;
				pixel_col <= cur_req.col;
				load_color <= cur_req.color;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// output side
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (expected_pixels.size() == 0) begin
				$display("%0t unexpected beat: expected none, actual target %0d color %06h",
					$time, target_index, pixel_color);
				mismatch_count++;
			end else begin
				want = expected_pixels.pop_front();
				if (target_index !== want.target) begin
					$display("%0t target_index: expected %0d actual %0d",
						$time, want.target, target_index);
					mismatch_count++;
				end
				if (pixel_color !== want.color) begin
					$display("%0t pixel_color: expected %06h actual %06h",
						$time, want.color, pixel_color);
					mismatch_count++;
				end
			end
		end
	end

	always @(negedge clk) begin
		if (hold_left != 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else if (!held_off && beats_in >= 400 && pending_reqs.size() > 40) begin
			// back up the pipe while the sender keeps going
			held_off = 1'b1;
			hold_left = HOLD_CYCLES;
			out_stall <= 1'b1;
		end else begin
			out_stall <= !steady_flow && ($urandom_range(99) < 29);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	initial begin
		wait (idle_cycles >= WATCHDOG_LIMIT);
		$display("tb_scrolled_frame_pixel_fetch failed");
		$finish;
	end

	initial begin : stimulus
		int rows, cols, span_r, span_c, orow, ocol;
		repeat (9) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// reset settings: full 32x32 frame, one frame, no shift
		queue_req(sfpf_pkg::OP_LOAD, 3'd0, 5'd0, 5'd0, 24'h000000);
		queue_req(sfpf_pkg::OP_LOAD, 3'd0, 5'd31, 5'd31, 24'hFFFFFF);
		queue_req(sfpf_pkg::OP_LOAD, 3'd7, 5'd31, 5'd31, 24'hA5A5A5);
		queue_req(sfpf_pkg::OP_LOAD, 3'd0, 5'd0, 5'd31, 24'h5A5A5A);
		queue_req(sfpf_pkg::OP_LOAD, 3'd0, 5'd31, 5'd0, 24'hFF0000);
		queue_req(sfpf_pkg::OP_DRAW, 3'd7, 5'd0, 5'd0, 24'hFFFFFF);
		queue_req(sfpf_pkg::OP_DRAW, 3'd0, 5'd31, 5'd31, 24'h000000);
		queue_req(sfpf_pkg::OP_DRAW, 3'd0, 5'd0, 5'd31, 24'h000000);
		queue_req(sfpf_pkg::OP_DRAW, 3'd0, 5'd31, 5'd0, 24'h000000);
		queue_req(sfpf_pkg::OP_NEXT, 3'd0, 5'd0, 5'd0, 24'h000000);
		queue_req(sfpf_pkg::OP_DRAW, 3'd0, 5'd0, 5'd0, 24'h000000);
		queue_req(sfpf_pkg::OP_PREV, 3'd7, 5'd31, 5'd31, 24'hFFFFFF);
		queue_req(sfpf_pkg::OP_DRAW, 3'd0, 5'd31, 5'd31, 24'h000000);
		queue_req(sfpf_pkg::OP_LOAD, 3'd0, 5'd31, 5'd31, 24'h00FF00);
		queue_req(sfpf_pkg::OP_DRAW, 3'd0, 5'd31, 5'd31, 24'h000000);

		run_phase(32, 32, 8, 0, 0, 1, 0, 0, 120);
		run_phase(16, 20, 3, 5, -7, 1, 10, 20, 120);
		run_phase(32, 32, 8, -32, 32, 1, 32, 32, 130);
		run_phase(8, 8, 2, 10, -3, 1, 0, 56, 100);
		run_phase(20, 20, 4, 3, 3, 0, 0, 0, 120);
		run_phase(32, 32, 5, 4, -4, 1, -10, 50, 130);
		// oversized geometry and frame count, placement wholly off the panel
		run_phase(63, 40, 15, -64, 63, 1, 127, -128, 80);
		// zero rows and zero frame count
		run_phase(0, 5, 0, 1, 1, 1, 0, 0, 60);
		run_phase(1, 1, 1, 0, 0, 1, 63, 63, 60);
		run_phase(32, 32, 8, 2, -3, 0, -3, 40, 120);

		repeat (6) begin
			rows = ($urandom_range(9) == 0) ? $urandom_range(63) : $urandom_range(1, 32);
			cols = ($urandom_range(9) == 0) ? $urandom_range(63) : $urandom_range(1, 32);
			span_r = sfpf_pkg::TGT_ROWS_DEF
				- ((rows > sfpf_pkg::SRC_ROWS_DEF) ? sfpf_pkg::SRC_ROWS_DEF : rows);
			span_c = sfpf_pkg::TGT_COLS_DEF
				- ((cols > sfpf_pkg::SRC_COLS_DEF) ? sfpf_pkg::SRC_COLS_DEF : cols);
			if ($urandom_range(1) == 0) begin
				orow = $urandom_range(span_r);
				ocol = $urandom_range(span_c);
			end else begin
				orow = int'($urandom_range(140)) - 70;
				ocol = int'($urandom_range(140)) - 70;
			end
			run_phase(rows, cols, $urandom_range(15), int'($urandom_range(24)) - 12,
				int'($urandom_range(24)) - 12, $urandom_range(1), orow, ocol, 140);
		end

		wait_idle();
		if (mismatch_count == 0 && expected_pixels.size() == 0) begin
			$display("tb_scrolled_frame_pixel_fetch passed");
		end else begin
			$display("tb_scrolled_frame_pixel_fetch failed");
		end
		$finish;
	end

endmodule
